/* rtl/core/mrdd_pkg.sv */
`default_nettype none

package mrdd_pkg;

	// Command operation codes
	localparam logic [1:0] OP_SET  = 2'd0;
	localparam logic [1:0] OP_RAMP = 2'd1;
	localparam logic [1:0] OP_STOP = 2'd2;

	// Register indexes (byte address = 4 * index)
	localparam logic [1:0] REG_DEADZONE  = 2'd0;
	localparam logic [1:0] REG_STEP_UP   = 2'd1;
	localparam logic [1:0] REG_STEP_DOWN = 2'd2;

	localparam int unsigned ADDR_W = 4;
	localparam int unsigned DATA_W = 32;

	localparam logic [7:0] DEADZONE_RST  = 8'd0;
	localparam logic [7:0] STEP_UP_RST   = 8'd5;
	localparam logic [7:0] STEP_DOWN_RST = 8'd5;

	localparam logic [7:0] DUTY_FULL = 8'd255;
	localparam logic [8:0] DUTY_DIV  = 9'd254;

	typedef logic signed [8:0] level_t;
	typedef logic signed [15:0] target_t;

	localparam level_t LEVEL_MAX = 9'sd255;
	localparam level_t LEVEL_MIN = -9'sd255;

	typedef struct packed {
		logic [7:0] deadzone;
		logic [7:0] step_up;
		logic [7:0] step_down;
	} cfg_t;

	// Magnitude of a saturated level (always fits 8 bits)
	function automatic logic [7:0] level_mag(input level_t v);
		logic [8:0] n;
		n = v[8] ? 9'(-v) : 9'(v);
		return n[7:0];
	endfunction

endpackage

`default_nettype wire

/* rtl/core/mrdd_cmd_if.sv */
`default_nettype none

interface mrdd_cmd_if import mrdd_pkg::*; ();
	logic       valid;
	logic       ready;
	logic [1:0] operation;
	target_t    target;

	modport source (output valid, output operation, output target, input ready);
	modport sink   (input valid, input operation, input target, output ready);
endinterface

`default_nettype wire

/* rtl/core/mrdd_res_if.sv */
`default_nettype none

interface mrdd_res_if import mrdd_pkg::*; ();
	logic       valid;
	logic       ready;
	logic       drive_forward;
	logic       drive_reverse;
	logic [7:0] duty;
	level_t     level;

	modport source (output valid, output drive_forward, output drive_reverse, output duty,
		output level, input ready);
	modport sink   (input valid, input drive_forward, input drive_reverse, input duty,
		input level, output ready);
endinterface

`default_nettype wire

/* rtl/core/motor_ramp_deadzone_drive_core.sv */
`default_nettype none

// Channel  Dir  Handshake           Payload
// cmd      in   valid / ready       operation[1:0], target[15:0] signed
// res      out  valid / ready       drive_forward, drive_reverse, duty[7:0], level[8:0] signed
// apb      in   psel/penable/pwrite paddr[3:0], pwdata[31:0], prdata[31:0], pready (tied high)
//
// One request enters per cycle unless the output stalls; after acceptance its result goes
// through level update into stage 2, remap multiply into stage 3, divide-by-254 into the output.
// The drive level loop closes in the first stage, so back-to-back requests see each
// other's level with no gap. Reset clears the level to zero, the registers to their
// defaults and all stage valid bits. Each stage holds while the stage after it is full
// and stalled, so the block keeps accepting until every stage is occupied.

module motor_ramp_deadzone_drive_core import mrdd_pkg::*; (
	input  wire logic              clk,
	input  wire logic              arst_n,
	mrdd_cmd_if.sink               cmd,
	mrdd_res_if.source             res,
	input  wire logic              psel,
	input  wire logic              penable,
	input  wire logic              pwrite,
	input  wire logic [ADDR_W-1:0] paddr,
	input  wire logic [DATA_W-1:0] pwdata,
	output logic      [DATA_W-1:0] prdata,
	output logic                   pready
);

	cfg_t   cfg;
	logic   lvl_valid;
	level_t lvl_level;
	logic   lvl_ready;

	// Register file: deadzone, up step, down step
	mrdd_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// Saturate the target and advance the stored drive level
	mrdd_level u_level (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.cmd       (cmd),
		.lvl_valid (lvl_valid),
		.lvl_level (lvl_level),
		.lvl_ready (lvl_ready)
	);

	// Remap the level magnitude to a deadzone-compensated duty and direction lines
	mrdd_remap u_remap (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.lvl_valid (lvl_valid),
		.lvl_level (lvl_level),
		.lvl_ready (lvl_ready),
		.res       (res)
	);

endmodule

`default_nettype wire

/* rtl/core/mrdd_cfg.sv */
`default_nettype none

module mrdd_cfg import mrdd_pkg::*; (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              psel,
	input  wire logic              penable,
	input  wire logic              pwrite,
	input  wire logic [ADDR_W-1:0] paddr,
	input  wire logic [DATA_W-1:0] pwdata,
	output logic      [DATA_W-1:0] prdata,
	output logic                   pready,
	output cfg_t                   cfg
);

	cfg_t       cfg_q;
	logic [1:0] idx;
	logic       wr_en;

	assign idx    = paddr[3:2];
	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.deadzone  <= DEADZONE_RST;
			cfg_q.step_up   <= STEP_UP_RST;
			cfg_q.step_down <= STEP_DOWN_RST;
		end else if (wr_en) begin
			unique case (idx)
				REG_DEADZONE:  cfg_q.deadzone  <= pwdata[7:0];
				REG_STEP_UP:   cfg_q.step_up   <= pwdata[7:0];
				REG_STEP_DOWN: cfg_q.step_down <= pwdata[7:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			REG_DEADZONE:  prdata = {24'd0, cfg_q.deadzone};
			REG_STEP_UP:   prdata = {24'd0, cfg_q.step_up};
			REG_STEP_DOWN: prdata = {24'd0, cfg_q.step_down};
			default:       prdata = '0;
		endcase
	end

endmodule

`default_nettype wire

/* rtl/core/mrdd_level.sv */
`default_nettype none

module mrdd_level import mrdd_pkg::*; (
	input  wire logic   clk,
	input  wire logic   arst_n,
	input  wire cfg_t   cfg,
	mrdd_cmd_if.sink    cmd,
	output logic        lvl_valid,
	output level_t      lvl_level,
	input  wire logic   lvl_ready
);

	logic        valid_s1;
	logic [1:0]  op_s1;
	target_t     target_s1;
	level_t      level_q;

	level_t      tgt;
	level_t      nxt;
	logic [7:0]  tgt_mag;
	logic [7:0]  lvl_mag;
	logic signed [9:0] diff;
	logic signed [9:0] ndiff;
	logic [8:0]  gap;
	logic [7:0]  step;
	logic [8:0]  move;
	logic signed [9:0] sum;

	assign cmd.ready = !valid_s1 || lvl_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (cmd.ready) begin
			valid_s1 <= cmd.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.ready && cmd.valid) begin
			op_s1     <= cmd.operation;
			target_s1 <= cmd.target;
		end
	end

	// Saturate the target to the drive range
	always_comb begin
		if (target_s1 > 16'(LEVEL_MAX)) begin
			tgt = LEVEL_MAX;
		end else if (target_s1 < 16'(LEVEL_MIN)) begin
			tgt = LEVEL_MIN;
		end else begin
			tgt = target_s1[8:0];
		end
	end

	always_comb begin
		tgt_mag = level_mag(tgt);
		lvl_mag = level_mag(level_q);
		diff    = 10'(tgt) - 10'(level_q);
		ndiff   = -diff;
		step    = cfg.step_up;
		gap     = 9'd0;
		move    = 9'd0;
		sum     = 10'(level_q);
		if (diff > 10'sd0) begin
			// moving up: growing magnitude uses the up step
			step = (tgt_mag > lvl_mag) ? cfg.step_up : cfg.step_down;
			gap  = diff[8:0];
			move = (gap < {1'b0, step}) ? gap : {1'b0, step};
			sum  = 10'(level_q) + $signed({1'b0, move});
		end else if (diff < 10'sd0) begin
			// moving down: shrinking magnitude uses the down step
			step = (tgt_mag < lvl_mag) ? cfg.step_down : cfg.step_up;
			gap  = ndiff[8:0];
			move = (gap < {1'b0, step}) ? gap : {1'b0, step};
			sum  = 10'(level_q) - $signed({1'b0, move});
		end
	end

	always_comb begin
		unique case (op_s1)
			OP_SET:  nxt = tgt;
			OP_RAMP: nxt = sum[8:0];
			OP_STOP: nxt = '0;
			default: nxt = level_q;
		endcase
	end

	// Commit the level when the command moves on to the remap stages
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			level_q <= '0;
		end else if (valid_s1 && lvl_ready) begin
			level_q <= nxt;
		end
	end

	assign lvl_valid = valid_s1;
	assign lvl_level = nxt;

endmodule

`default_nettype wire

/* rtl/core/mrdd_remap.sv */
`default_nettype none

module mrdd_remap import mrdd_pkg::*; (
	input  wire logic   clk,
	input  wire logic   arst_n,
	input  wire cfg_t   cfg,
	input  wire logic   lvl_valid,
	input  wire level_t lvl_level,
	output logic        lvl_ready,
	mrdd_res_if.source  res
);

	logic        valid_s2;
	logic        valid_s3;
	logic        valid_s4;
	level_t      level_s2;
	level_t      level_s3;
	level_t      level_s4;
	logic [15:0] prod_s3;
	logic        zero_s3;
	logic [7:0]  duty_s4;
	logic        fwd_s4;
	logic        rev_s4;

	logic        rdy_s2;
	logic        rdy_s3;
	logic        rdy_s4;

	logic [7:0]  mag;
	logic [7:0]  mag_m1;
	logic [7:0]  span;

	logic [16:0] est_sum;
	logic [8:0]  quo_est;
	logic [16:0] rem;
	logic [8:0]  quo;
	logic [8:0]  duty_w;
	logic [7:0]  duty;

	assign rdy_s4    = !valid_s4 || res.ready;
	assign rdy_s3    = !valid_s3 || rdy_s4;
	assign rdy_s2    = !valid_s2 || rdy_s3;
	assign lvl_ready = rdy_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else begin
			if (rdy_s2) valid_s2 <= lvl_valid;
			if (rdy_s3) valid_s3 <= valid_s2;
			if (rdy_s4) valid_s4 <= valid_s3;
		end
	end

	// Stage 2: (m - 1) * (255 - deadzone)
	assign mag    = level_mag(level_s2);
	assign mag_m1 = mag - 8'd1;
	assign span   = DUTY_FULL - cfg.deadzone;

	always_ff @(posedge clk) begin
		if (rdy_s2 && lvl_valid) begin
			level_s2 <= lvl_level;
		end
		if (rdy_s3 && valid_s2) begin
			level_s3 <= level_s2;
			zero_s3  <= (mag == 8'd0);
			prod_s3  <= mag_m1 * span;
		end
	end

	// Stage 3: divide by 254 as p/256 * (1 + 1/128 + 1/16384), then fix up by one
	always_comb begin
		est_sum = 17'(prod_s3) + 17'(prod_s3 >> 7) + 17'(prod_s3 >> 14);
		quo_est = est_sum[16:8];
		rem     = 17'(prod_s3) - (17'(quo_est) << 8) + (17'(quo_est) << 1);
		quo     = (rem >= 17'(DUTY_DIV)) ? quo_est + 9'd1 : quo_est;
		duty_w  = quo + 9'(cfg.deadzone);
		duty    = zero_s3 ? 8'd0 : duty_w[7:0];
	end

	always_ff @(posedge clk) begin
		if (rdy_s4 && valid_s3) begin
			level_s4 <= level_s3;
			duty_s4  <= duty;
			fwd_s4   <= (duty != 8'd0) && !level_s3[8] && (level_s3 != '0);
			rev_s4   <= (duty != 8'd0) && level_s3[8];
		end
	end

	assign res.valid         = valid_s4;
	assign res.drive_forward = fwd_s4;
	assign res.drive_reverse = rev_s4;
	assign res.duty          = duty_s4;
	assign res.level         = level_s4;

endmodule

`default_nettype wire
